// ===== rtl/qsps_pkg.sv =====
// Shared types and helpers for the query string pair splitter.
// Holds the input and result beat structs, the character codes and the
// escape digit map. No dependencies.
package qsps_pkg;

  // Character codes that steer the parser
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  // One input beat: a raw byte and the end of message flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } qsps_in_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_value;
    logic       key_done;
    logic       pair_done;
    logic       pair_dropped;
  } qsps_out_t;

  // Escape digit map: 0-9 count 0..9, any letter counts from 10 (up to 35),
  // everything else counts 0
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
        v = c - CH_ZERO;
      end else if (c inside {[8'h41:8'h5A]}) begin
        v = c - CH_UPPER_A + LETTER_BASE;
      end else if (c inside {[8'h61:8'h7A]}) begin
        v = c - CH_LOWER_A + LETTER_BASE;
      end
      digit_value = v[5:0];
    end
  endfunction

endpackage

// ===== rtl/query_string_pair_splitter_unit.sv =====
// Query string pair splitter: top level with parser state and result register.
// Depends on qsps_pkg for the beat structs, character codes and digit map.
//
// Takes one query string byte per beat and takes a new beat every cycle as
// long as the result register is free or being drained in the same cycle.
// Each accepted byte is parsed by combinational logic against the pair
// and escape state; a byte that yields anything (a key byte, a decoded value
// byte, key done, pair done or pair dropped) shows up on the result channel
// in the cycle after acceptance. Leading spaces produce no beat; the '%' that
// opens an escape and its first digit produce none unless they end the
// message; the '&' that closes a value gives a pair done beat without a byte.
// The single result register holds each result; in_stall rises only while a
// result waits with out_stall high.
module query_string_pair_splitter_unit
  import qsps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  qsps_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output qsps_out_t out_data
);

  typedef enum logic [2:0] {
    PH_SEEK_KEY = 3'b001,
    PH_IN_KEY   = 3'b010,
    PH_VALUE    = 3'b100
  } pair_phase_t;

  typedef enum logic [2:0] {
    ESC_NORMAL = 3'b001,
    ESC_FIRST  = 3'b010,
    ESC_SECOND = 3'b100
  } esc_phase_t;

  pair_phase_t phase_r, phase_nxt;
  esc_phase_t  esc_r, esc_nxt;
  logic [5:0]  first_digit_r, first_digit_nxt;
  logic        out_valid_r, out_valid_nxt;
  qsps_out_t   out_data_r, out_data_nxt;
  qsps_out_t   res;
  logic        has_res;
  logic        in_accept;
  logic        out_free;
  logic [7:0]  c;
  logic        last;
  logic [5:0]  dval;

  assign c    = in_data.in_byte;
  assign last = in_data.last_byte;
  assign dval = digit_value(c);

  // Stall input only while a result is held back
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !out_free;
  assign in_accept = in_valid && out_free;

  // Parse one byte against the current pair and escape state
  always_comb begin
    phase_nxt       = phase_r;
    esc_nxt         = esc_r;
    first_digit_nxt = first_digit_r;
    res             = '0;
    case (phase_r)
      PH_IN_KEY: begin
        if (c == CH_EQUALS) begin
          res.key_done = 1'b1;
          phase_nxt    = PH_VALUE;
          esc_nxt      = ESC_NORMAL;
        end else begin
          res.out_byte   = c;
          res.byte_valid = 1'b1;
        end
        res.pair_dropped = last;
      end
      PH_VALUE: begin
        if (c == CH_AMP) begin
          res.pair_done = 1'b1;
          phase_nxt     = PH_SEEK_KEY;
          esc_nxt       = ESC_NORMAL;
        end else begin
          case (esc_r)
            ESC_FIRST: begin
              first_digit_nxt = dval;
              esc_nxt         = ESC_SECOND;
            end
            ESC_SECOND: begin
              res.out_byte   = {first_digit_r[3:0], 4'b0000} + {2'b00, dval};
              res.byte_valid = 1'b1;
              res.is_value   = 1'b1;
              esc_nxt        = ESC_NORMAL;
            end
            default: begin
              if (c == CH_PERCENT) begin
                esc_nxt = ESC_FIRST;
              end else begin
                res.out_byte   = (c == CH_PLUS) ? CH_SPACE : c;
                res.byte_valid = 1'b1;
                res.is_value   = 1'b1;
                esc_nxt        = ESC_NORMAL;
              end
            end
          endcase
          res.pair_done = last;
        end
      end
      default: begin
        // Skip leading spaces, anything else opens the key
        if (c != CH_SPACE) begin
          res.out_byte     = c;
          res.byte_valid   = 1'b1;
          res.pair_dropped = last;
          phase_nxt        = PH_IN_KEY;
        end
      end
    endcase
    // Return to idle at message end
    if (last) begin
      phase_nxt = PH_SEEK_KEY;
      esc_nxt   = ESC_NORMAL;
    end
  end

  assign has_res = res.byte_valid || res.key_done || res.pair_done || res.pair_dropped;

  // Load the result register when it is free, hold otherwise
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = in_accept && has_res;
      out_data_nxt  = res;
    end
  end

  // Advance parser state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SEEK_KEY;
      esc_r         <= ESC_NORMAL;
      first_digit_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r       <= phase_nxt;
        esc_r         <= esc_nxt;
        first_digit_r <= first_digit_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result beat always carries at least one flag
  a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.byte_valid || out_data_r.key_done ||
                     out_data_r.pair_done || out_data_r.pair_dropped))
    else $error("empty result beat");

  // A beat without a byte carries a zero byte and no value mark
  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.byte_valid) |->
      (out_data_r.out_byte == 8'd0 && !out_data_r.is_value))
    else $error("stray byte data without byte_valid");

  // Message end returns the parser to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && last) |=> (phase_r == PH_SEEK_KEY && esc_r == ESC_NORMAL))
    else $error("parser not idle after message end");

  // Closing a key never comes with a byte
  a_key_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.key_done) |->
      (!out_data_r.byte_valid && !out_data_r.pair_done))
    else $error("key_done with byte or pair_done");

  // An escape is only pending inside a value
  a_esc_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    (esc_r != ESC_NORMAL) |-> (phase_r == PH_VALUE))
    else $error("escape pending outside value");

endmodule
